@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the positional array block.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pais_pkg.sv @@
// Shared constants, operation and status codes and the result struct
// of the positional array block. Depends on nothing.
package pais_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        found_position;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
    } result_t;

endpackage

@@ design/positional_array_insert_delete_search.sv @@
// Channel  Ports                                         Dir  Role
// s_       s_valid s_ready s_kind s_position s_value     in   operation item
// m_       m_valid m_ready m_status m_found_position       out  result item
//          m_read_value m_count
//
// Search walks the elements from the front until a match; read fetches one entry;
// a delete shifts the later elements down, an insert shifts the elements from its
// position up and then writes the new value. Clear, error items, unused kinds and
// a delete of the last element touch no entry; an insert at the end only writes.
// The element RAM reads one entry and writes one entry per cycle.
// Reset empties the array; no clearing pass is run. A stalled result sits in
// the output register while the next item is taken.
// Top level of the positional array: element RAM, sequencer, output register.
// Depends on pais_pkg, pais_ram, pais_seq and assert_macros.svh.
`include "assert_macros.svh"

module positional_array_insert_delete_search import pais_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KIND_W-1:0]       s_kind,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic [POS_W-1:0]        m_found_position,
    output logic signed [VAL_W-1:0] m_read_value,
    output logic [CNT_W-1:0]        m_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic [CW-1:0]    cnt;
    logic             rw_clash;

    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;

    pais_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pais_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_kind   (s_kind),
        .in_pos    (s_position),
        .in_value  (s_value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cnt       (cnt)
    );

    // load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_found_position = out_reg.found_position;
    assign m_read_value     = out_reg.read_value;
    assign m_count          = out_reg.count;

    assign rw_clash = mem_we && mem_re && (mem_waddr == mem_raddr);

    `ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt <= CW'(DEPTH), "element count above depth")
    `ASSERT_ALWAYS(a_rw_apart, aclk, aresetn, !rw_clash, "read and write hit one entry")
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "item taken while busy")

endmodule

@@ design/pais_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module pais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/pais_seq.sv @@
// Operation sequencer: checks each item, holds the element count and walks the
// element RAM for shifts, search and read. Depends on pais_pkg.
module pais_seq import pais_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [KIND_W-1:0]            in_kind,
    input  logic [POS_W-1:0]             in_pos,
    input  logic signed [VAL_W-1:0]      in_value,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic [VAL_W-1:0]             mem_wdata,
    output logic                         mem_re,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr,
    input  logic [VAL_W-1:0]             mem_rdata,
    output logic                         res_valid,
    input  logic                         res_ready,
    output result_t                      res,
    output logic [$clog2(DEPTH+1)-1:0]   cnt
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int FW   = (AW > POS_W) ? AW : POS_W;
    localparam int OW   = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              issue_reg, issue_next;
    logic              dv_reg, dv_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     tag_reg, tag_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [KIND_W-1:0] op_reg, op_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [POS_W-1:0]  fpos_reg, fpos_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;

    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] pos_ext;
    logic [CW-1:0]   cnt_m1;
    logic [FW-1:0]   tag_wide;
    logic [OW-1:0]   cnt_wide;

    assign cnt_ext  = CMPW'(cnt_reg);
    assign pos_ext  = CMPW'(in_pos);
    assign cnt_m1   = cnt_reg - 1'b1;
    assign tag_wide = FW'(tag_reg);
    assign cnt_wide = OW'(cnt_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign cnt       = cnt_reg;

    assign res.status         = stat_reg;
    assign res.found_position = fpos_reg;
    assign res.read_value     = rval_reg;
    assign res.count          = cnt_wide[CNT_W-1:0];

    always_comb begin
        state_next = state_reg;
        issue_next = issue_reg;
        dv_next    = dv_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        tag_next   = tag_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        fpos_next  = fpos_reg;
        rval_next  = rval_reg;
        mem_we     = 1'b0;
        mem_waddr  = tag_reg;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_kind;
                    val_next   = in_value;
                    pos_next   = pos_ext[AW-1:0];
                    stat_next  = STAT_OK;
                    fpos_next  = '0;
                    rval_next  = '0;
                    issue_next = 1'b0;
                    dv_next    = 1'b0;
                    state_next = ST_DONE;
                    case (in_kind)
                        KIND_CLEAR: begin
                            cnt_next = '0;
                        end
                        KIND_INSERT: begin
                            if (cnt_ext == CMPW'(DEPTH)) begin
                                stat_next = STAT_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                stat_next = STAT_BADPOS;
                            end else if (pos_ext == cnt_ext) begin
                                state_next = ST_PUT;
                            end else begin
                                state_next = ST_RUN;
                                issue_next = 1'b1;
                                idx_next   = cnt_m1[AW-1:0];
                                last_next  = pos_ext[AW-1:0];
                            end
                        end
                        KIND_DELETE: begin
                            if (cnt_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                stat_next = STAT_BADPOS;
                            end else if (pos_ext == CMPW'(cnt_m1)) begin
                                cnt_next = cnt_m1;
                            end else begin
                                state_next = ST_RUN;
                                issue_next = 1'b1;
                                idx_next   = AW'(pos_ext + 1'b1);
                                last_next  = cnt_m1[AW-1:0];
                            end
                        end
                        KIND_SEARCH: begin
                            if (cnt_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_RUN;
                                issue_next = 1'b1;
                                idx_next   = '0;
                                last_next  = cnt_m1[AW-1:0];
                            end
                        end
                        KIND_READ: begin
                            if (cnt_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                stat_next = STAT_BADPOS;
                            end else begin
                                state_next = ST_RUN;
                                issue_next = 1'b1;
                                idx_next   = pos_ext[AW-1:0];
                                last_next  = pos_ext[AW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // issue one read per cycle, consume the data of the previous one
                mem_re   = issue_reg;
                dv_next  = issue_reg;
                tag_next = idx_reg;
                if (issue_reg) begin
                    if (idx_reg == last_reg) begin
                        issue_next = 1'b0;
                    end else if (op_reg == KIND_INSERT) begin
                        idx_next = idx_reg - 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (dv_reg) begin
                    case (op_reg)
                        KIND_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(tag_reg + 1'b1);
                            if (!issue_reg) begin
                                state_next = ST_PUT;
                            end
                        end
                        KIND_DELETE: begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(tag_reg - 1'b1);
                            if (!issue_reg) begin
                                cnt_next   = cnt_m1;
                                state_next = ST_DONE;
                            end
                        end
                        KIND_SEARCH: begin
                            if (mem_rdata == val_reg) begin
                                stat_next  = STAT_OK;
                                fpos_next  = tag_wide[POS_W-1:0];
                                issue_next = 1'b0;
                                state_next = ST_DONE;
                            end else if (!issue_reg) begin
                                stat_next  = STAT_NOTFOUND;
                                state_next = ST_DONE;
                            end
                        end
                        KIND_READ: begin
                            rval_next  = mem_rdata;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issue_reg <= 1'b0;
            dv_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            dv_reg    <= dv_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
        tag_reg  <= tag_next;
        pos_reg  <= pos_next;
        op_reg   <= op_next;
        val_reg  <= val_next;
        stat_reg <= stat_next;
        fpos_reg <= fpos_next;
        rval_reg <= rval_next;
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for positional_array_insert_delete_search: a directed table, then
// random well-formed episodes and noise, checked against a shadow copy of the array.
// Depends on pais_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb import pais_pkg::*; ();

    localparam int DEPTH        = DEPTH_DEF;
    localparam int NUM_ITEMS    = 700;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        result_t                 res;
    } op_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam op_row_t DIRECTED_OPS [NUM_DIRECTED] = '{
        '{KIND_SEARCH, 6'd0,  32'sh0000_0000, 1'b1, '{STAT_EMPTY,    6'd0, 32'sh0, 7'd0}},
        '{KIND_READ,   6'd0,  32'sh0000_0000, 1'b1, '{STAT_EMPTY,    6'd0, 32'sh0, 7'd0}},
        '{KIND_DELETE, 6'd0,  32'sh0000_0000, 1'b1, '{STAT_EMPTY,    6'd0, 32'sh0, 7'd0}},
        '{KIND_INSERT, 6'd1,  32'sh0000_0001, 1'b1, '{STAT_BADPOS,   6'd0, 32'sh0, 7'd0}},
        '{KIND_INSERT, 6'd0,  32'sh8000_0000, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd1}},
        '{KIND_INSERT, 6'd1,  32'sh7fff_ffff, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd2}},
        '{KIND_READ,   6'd0,  32'sh0000_0000, 1'b1,
          '{STAT_OK, 6'd0, 32'sh8000_0000, 7'd2}},
        '{KIND_READ,   6'd1,  32'sh0000_0000, 1'b1,
          '{STAT_OK, 6'd0, 32'sh7fff_ffff, 7'd2}},
        '{KIND_READ,   6'd63, 32'sh0000_0000, 1'b1, '{STAT_BADPOS,   6'd0, 32'sh0, 7'd2}},
        '{KIND_DELETE, 6'd2,  32'sh0000_0000, 1'b1, '{STAT_BADPOS,   6'd0, 32'sh0, 7'd2}},
        '{KIND_INSERT, 6'd63, 32'sh0000_0005, 1'b1, '{STAT_BADPOS,   6'd0, 32'sh0, 7'd2}},
        '{KIND_SEARCH, 6'd0,  32'sh7fff_ffff, 1'b1, '{STAT_OK,       6'd1, 32'sh0, 7'd2}},
        '{KIND_SEARCH, 6'd63, 32'sh0000_0000, 1'b1, '{STAT_NOTFOUND, 6'd0, 32'sh0, 7'd2}},
        '{KIND_SPARE5, 6'd63, 32'shffff_ffff, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd2}},
        '{KIND_SPARE6, 6'd0,  32'sh0000_0000, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd2}},
        '{KIND_SPARE7, 6'd63, 32'sh7fff_ffff, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd2}},
        '{KIND_INSERT, 6'd0,  32'sh7fff_ffff, 1'b0, '0},
        '{KIND_SEARCH, 6'd0,  32'sh7fff_ffff, 1'b0, '0},
        '{KIND_INSERT, 6'd3,  32'shffff_ffff, 1'b0, '0},
        '{KIND_DELETE, 6'd0,  32'sh0000_0000, 1'b0, '0},
        '{KIND_READ,   6'd2,  32'sh0000_0000, 1'b0, '0},
        '{KIND_DELETE, 6'd2,  32'sh0000_0000, 1'b0, '0},
        '{KIND_CLEAR,  6'd63, 32'shffff_ffff, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd0}},
        '{KIND_READ,   6'd0,  32'sh0000_0000, 1'b1, '{STAT_EMPTY,    6'd0, 32'sh0, 7'd0}},
        '{KIND_INSERT, 6'd0,  32'sh0000_0000, 1'b1, '{STAT_OK,       6'd0, 32'sh0, 7'd1}}
    };

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [KIND_W-1:0]       s_kind     = KIND_CLEAR;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value    = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STAT_W-1:0]       m_status;
    logic [POS_W-1:0]        m_found_position;
    logic signed [VAL_W-1:0] m_read_value;
    logic [CNT_W-1:0]        m_count;

    logic signed [VAL_W-1:0] shadow_elems [DEPTH];
    int                      shadow_count = 0;
    result_t                 pending_results [$];
    result_t                 oldest;
    int                      mismatches = 0;
    int                      items_sent = 0;
    int                      burst_left = 0;
    logic                    hold_request = 1'b0;
    bit                      hold_done = 1'b0;
    int                      hold_left = 0;
    int                      rx_mode = 0;
    int                      rx_mode_left = 0;

    positional_array_insert_delete_search #(.DEPTH(DEPTH)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_read_value     (m_read_value),
        .m_count          (m_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic result_t apply_array_op(input logic [KIND_W-1:0] kind,
                                               input logic [POS_W-1:0] pos,
                                               input logic signed [VAL_W-1:0] val);
        result_t r;
        int      i;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            KIND_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (pos > shadow_count) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[pos] = val;
                    shadow_count++;
                end
            end
            KIND_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (pos >= shadow_count) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_count--;
                end
            end
            KIND_SEARCH: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (i = 0; i < shadow_count && !hit; i++) begin
                        if (shadow_elems[i] == val) begin
                            hit = 1'b1;
                            r.found_position = POS_W'(i);
                        end
                    end
                    if (!hit)
                        r.status = STAT_NOTFOUND;
                end
            end
            KIND_READ: begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else if (pos >= shadow_count)
                    r.status = STAT_BADPOS;
                else
                    r.read_value = shadow_elems[pos];
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return VAL_W'($urandom_range(0, 8)) - 4;
            3:       return 32'sh8000_0000;
            4:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item in bursts with random gaps; predict on accept.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input logic typed,
                           input result_t typed_res);
        result_t predicted;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_array_op(kind, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic send_mixed_op();
        int                      pick;
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        pos  = POS_W'($urandom_range(0, 63));
        val  = random_value();
        if (pick < 30) begin
            kind = KIND_INSERT;
            if (shadow_count < DEPTH)
                pos = POS_W'($urandom_range(0, shadow_count));
        end else if (pick < 50) begin
            kind = KIND_DELETE;
            if (shadow_count > 0)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
        end else if (pick < 75) begin
            kind = KIND_SEARCH;
            if (shadow_count > 0)
                val = shadow_elems[$urandom_range(0, shadow_count - 1)];
        end else if (pick < 80) begin
            kind = KIND_SEARCH;
        end else if (pick < 95) begin
            kind = KIND_READ;
            if (shadow_count > 0)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
        end else begin
            kind = KIND_W'($urandom_range(0, 7));
        end
        send_op(kind, pos, val, 1'b0, '0);
    endtask

    // Receiver: long hold-off once on request, otherwise a changing stall pattern.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, status %0d count %0d",
                         $time, m_status, m_count);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_status !== oldest.status) begin
                    $display("%0t: status expected %0d got %0d", $time, oldest.status, m_status);
                    mismatches++;
                end
                if (m_found_position !== oldest.found_position) begin
                    $display("%0t: found_position expected %0d got %0d",
                             $time, oldest.found_position, m_found_position);
                    mismatches++;
                end
                if (m_read_value !== oldest.read_value) begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, oldest.read_value, m_read_value);
                    mismatches++;
                end
                if (m_count !== oldest.count) begin
                    $display("%0t: count expected %0d got %0d", $time, oldest.count, m_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int episode;
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_OPS[i])
            send_op(DIRECTED_OPS[i].kind, DIRECTED_OPS[i].position, DIRECTED_OPS[i].value,
                    DIRECTED_OPS[i].typed, DIRECTED_OPS[i].res);

        episode = 0;
        while (items_sent < NUM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (episode == 0 || pick == 0) begin
                if (episode == 0)
                    hold_request <= 1'b1;
                send_op(KIND_CLEAR, POS_W'($urandom_range(0, 63)), $urandom, 1'b0, '0);
                while (shadow_count < DEPTH)
                    send_op(KIND_INSERT, POS_W'($urandom_range(0, shadow_count)),
                            random_value(), 1'b0, '0);
                repeat (3)
                    send_op(KIND_INSERT, POS_W'($urandom_range(0, 63)), random_value(),
                            1'b0, '0);
                send_op(KIND_READ, POS_W'(DEPTH - 1), random_value(), 1'b0, '0);
                send_op(KIND_SEARCH, POS_W'($urandom_range(0, 63)), shadow_elems[DEPTH-1],
                        1'b0, '0);
                send_op(KIND_DELETE, POS_W'($urandom_range(0, 63)), random_value(), 1'b0, '0);
                repeat ($urandom_range(4, 20)) send_mixed_op();
            end else if (pick < 7) begin
                send_op(KIND_CLEAR, POS_W'($urandom_range(0, 63)), $urandom, 1'b0, '0);
                repeat ($urandom_range(1, 16))
                    send_op(KIND_INSERT, POS_W'($urandom_range(0, shadow_count)),
                            random_value(), 1'b0, '0);
                repeat ($urandom_range(4, 30)) send_mixed_op();
            end else begin
                repeat ($urandom_range(1, 10))
                    send_op(KIND_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 63)),
                            $urandom, 1'b0, '0);
            end
            episode++;
        end
        s_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[positional_array_insert_delete_search] OK");
        else
            $display("[positional_array_insert_delete_search] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[positional_array_insert_delete_search] ERROR");
        $finish;
    end

endmodule
